### sv/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types, constants and microcode program of the signed decimal
// field formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_WIDTH_DEF  = 63;

    // bits converted per double-dabble step
    localparam int DAB_BITS = 4;

    // configuration register file
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int FW_W       = 6;
    localparam int PREC_W     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ALIGN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PAD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREC_EN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PREC_DIGITS = 3'd4;

    // ASCII
    localparam int CHAR_W = 7;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    // microcode
    localparam int PC_W = 4;

    typedef enum logic [2:0] {
        OP_IDLE    = 3'd0,
        OP_CONV    = 3'd1,
        OP_MEASURE = 3'd2,
        OP_PLAN1   = 3'd3,
        OP_PLAN2   = 3'd4,
        OP_EMIT    = 3'd5,
        OP_NOP     = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        SEG_NONE   = 3'd0,
        SEG_LEAD   = 3'd1,
        SEG_SIGN   = 3'd2,
        SEG_ZEROS  = 3'd3,
        SEG_DIGITS = 3'd4,
        SEG_TRAIL  = 3'd5
    } t_seg;

    // jump taken when the condition holds, otherwise fall through
    typedef enum logic [2:0] {
        C_NEVER  = 3'd0,
        C_ALWAYS = 3'd1,
        C_NO_IN  = 3'd2,
        C_LOOP   = 3'd3,
        C_BUSY   = 3'd4
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_seg            seg;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_xfer;
        logic loop;
        logic busy;
    } t_flags;

    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_CONV  = 4'd1;
    localparam logic [PC_W-1:0] PC_LEAD  = 4'd5;
    localparam logic [PC_W-1:0] PC_SIGN  = 4'd6;
    localparam logic [PC_W-1:0] PC_ZEROS = 4'd7;
    localparam logic [PC_W-1:0] PC_DIGS  = 4'd8;
    localparam logic [PC_W-1:0] PC_TRAIL = 4'd9;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NOP, seg: SEG_NONE, cond: C_ALWAYS, target: PC_IDLE};
        unique case (pc)
            4'd0:  w = '{op: OP_IDLE,    seg: SEG_NONE,   cond: C_NO_IN,  target: PC_IDLE};
            4'd1:  w = '{op: OP_CONV,    seg: SEG_NONE,   cond: C_LOOP,   target: PC_CONV};
            4'd2:  w = '{op: OP_MEASURE, seg: SEG_NONE,   cond: C_NEVER,  target: PC_IDLE};
            4'd3:  w = '{op: OP_PLAN1,   seg: SEG_NONE,   cond: C_NEVER,  target: PC_IDLE};
            4'd4:  w = '{op: OP_PLAN2,   seg: SEG_NONE,   cond: C_NEVER,  target: PC_IDLE};
            4'd5:  w = '{op: OP_EMIT,    seg: SEG_LEAD,   cond: C_BUSY,   target: PC_LEAD};
            4'd6:  w = '{op: OP_EMIT,    seg: SEG_SIGN,   cond: C_BUSY,   target: PC_SIGN};
            4'd7:  w = '{op: OP_EMIT,    seg: SEG_ZEROS,  cond: C_BUSY,   target: PC_ZEROS};
            4'd8:  w = '{op: OP_EMIT,    seg: SEG_DIGITS, cond: C_BUSY,   target: PC_DIGS};
            4'd9:  w = '{op: OP_EMIT,    seg: SEG_TRAIL,  cond: C_BUSY,   target: PC_TRAIL};
            4'd10: w = '{op: OP_NOP,     seg: SEG_NONE,   cond: C_ALWAYS, target: PC_IDLE};
            default: w = '{op: OP_NOP,   seg: SEG_NONE,   cond: C_ALWAYS, target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

### sv/signed_decimal_field_formatter_core.sv
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter_core
// Formats a signed integer as printf %d text, one ASCII character per
// output transfer, with width, precision, zero fill and left alignment.
// ----------------------------------------------------------------------------
// Flow: an input transfer starts the conversion loop, then a measure and two planning
//   steps, then the five segments in order (lead, sign, zeros, digits, trail); an
//   empty segment is still stepped through. Output characters are registered.
// Throughput: a new item is taken only after every segment of the last one is done;
//   one character per cycle while the output register is free or being taken.
// Reset: synchronous, active low; clears sequencer, output valid and config to 0.
module signed_decimal_field_formatter_core #(
    parameter int VALUE_BITS = sdf_pkg::VALUE_BITS_DEF,
    parameter int MAX_WIDTH  = sdf_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [sdf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sdf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [VALUE_BITS-1:0]      i_value,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sdf_pkg::CHAR_W-1:0]        o_char_out,
    output logic                              o_last_char
);
    import sdf_pkg::*;

    // digits needed for a magnitude up to 2^(VALUE_BITS-1)
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DIG_W      = $clog2(NUM_DIGITS + 1);
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CONV_STEPS = (VALUE_BITS + DAB_BITS - 1) / DAB_BITS;
    localparam int CONV_BITS  = CONV_STEPS * DAB_BITS;
    localparam int STEP_W     = $clog2(CONV_STEPS + 1);
    localparam int CNT_W      = $clog2(MAX_WIDTH + NUM_DIGITS + 2);
    localparam int LEFT_W     = $clog2(MAX_WIDTH + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic              r_left_align, r_zero_pad, r_prec_en;
    logic [FW_W-1:0]   r_field_width;
    logic [PREC_W-1:0] r_prec;

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic                  r_neg, n_neg;
    logic                  r_mag_zero, n_mag_zero;
    logic [CONV_BITS-1:0]  r_shreg, n_shreg;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [STEP_W-1:0]     r_cnt, n_cnt;
    logic [DIG_W-1:0]      r_ndig, n_ndig;
    logic [CNT_W-1:0]      r_zeros, n_zeros;
    logic [CNT_W-1:0]      r_len, n_len;
    logic [CNT_W-1:0]      r_pad, n_pad;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_uword uw;
    t_flags flags;

    sdf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw)
    );

    logic in_xfer;
    assign o_in_ready = (uw.op == OP_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    // magnitude of the input; the most negative value wraps to 2^(N-1)
    logic [VALUE_BITS-1:0] in_mag;
    assign in_mag = i_value[VALUE_BITS-1] ? (~i_value + VALUE_BITS'(1)) : i_value;

    // ------------------------------------------------------------------
    // Double dabble, DAB_BITS bits per conversion step
    // ------------------------------------------------------------------
    logic [BCD_W-1:0]     dab_bcd;
    logic [CONV_BITS-1:0] dab_sh;

    always_comb begin
        dab_bcd = r_bcd;
        dab_sh  = r_shreg;
        for (int s = 0; s < DAB_BITS; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (dab_bcd[d*4 +: 4] >= 4'd5)
                    dab_bcd[d*4 +: 4] = dab_bcd[d*4 +: 4] + 4'd3;
            end
            dab_bcd = {dab_bcd[BCD_W-2:0], dab_sh[CONV_BITS-1]};
            dab_sh  = {dab_sh[CONV_BITS-2:0], 1'b0};
        end
    end

    // digit count: highest nonzero BCD digit, at least one
    logic [DIG_W-1:0] meas_ndig;

    always_comb begin
        meas_ndig = DIG_W'(1);
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] != 4'd0)
                meas_ndig = DIG_W'(d + 1);
        end
    end

    // ------------------------------------------------------------------
    // Layout arithmetic (width and precision saturated to the field cap)
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] w_sat, p_sat, ndig_ext, body, pad_raw, total;

    assign w_sat    = (CNT_W'(r_field_width) > CNT_W'(MAX_WIDTH))
                      ? CNT_W'(MAX_WIDTH) : CNT_W'(r_field_width);
    assign p_sat    = (CNT_W'(r_prec) > CNT_W'(MAX_WIDTH - 1))
                      ? CNT_W'(MAX_WIDTH - 1) : CNT_W'(r_prec);
    assign ndig_ext = CNT_W'(r_ndig);
    assign body     = (r_prec_en && (p_sat > ndig_ext)) ? p_sat : ndig_ext;
    assign pad_raw  = (w_sat > r_len) ? (w_sat - r_len) : '0;
    assign total    = r_len + pad_raw;

    logic zero_fill;
    assign zero_fill = r_zero_pad && !r_left_align && !r_prec_en;

    // ------------------------------------------------------------------
    // Segment emission
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  cnt_sel;
    logic [CHAR_W-1:0] seg_char;
    logic [DIG_W-1:0]  dig_pos;
    logic [IDX_W-1:0]  dig_idx;
    logic [3:0]        dig_val;
    logic              can_emit, has_char, emit_fire;

    assign dig_pos = r_ndig - DIG_W'(1);
    assign dig_idx = dig_pos[IDX_W-1:0];
    assign dig_val = r_bcd[{dig_idx, 2'b00} +: 4];

    always_comb begin
        unique case (uw.seg)
            SEG_LEAD: begin
                cnt_sel  = r_left_align ? '0 : r_pad;
                seg_char = CHAR_SPACE;
            end
            SEG_SIGN: begin
                cnt_sel  = CNT_W'(r_neg);
                seg_char = CHAR_MINUS;
            end
            SEG_ZEROS: begin
                cnt_sel  = r_zeros;
                seg_char = CHAR_ZERO;
            end
            SEG_DIGITS: begin
                cnt_sel  = CNT_W'(r_ndig);
                seg_char = CHAR_ZERO + CHAR_W'(dig_val);
            end
            SEG_TRAIL: begin
                cnt_sel  = r_left_align ? r_pad : '0;
                seg_char = CHAR_SPACE;
            end
            default: begin
                cnt_sel  = '0;
                seg_char = CHAR_SPACE;
            end
        endcase
    end

    // output register frees up in the same cycle it is taken
    assign can_emit  = !r_out_valid || i_out_ready;
    // r_left cuts overlong text at the field cap
    assign has_char  = (uw.op == OP_EMIT) && (cnt_sel != '0) && (r_left != '0);
    assign emit_fire = has_char && can_emit;

    assign flags.in_xfer = in_xfer;
    assign flags.loop    = (r_cnt > STEP_W'(1));
    assign flags.busy    = has_char
                           && !(emit_fire && ((cnt_sel == CNT_W'(1)) || (r_left == LEFT_W'(1))));

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_neg      = r_neg;
        n_mag_zero = r_mag_zero;
        n_shreg    = r_shreg;
        n_bcd      = r_bcd;
        n_cnt      = r_cnt;
        n_ndig     = r_ndig;
        n_zeros    = r_zeros;
        n_len      = r_len;
        n_pad      = r_pad;
        n_left     = r_left;
        n_out_char = r_out_char;
        n_out_last = r_out_last;

        unique case (uw.op)
            OP_IDLE: begin
                if (in_xfer) begin
                    n_neg      = i_value[VALUE_BITS-1];
                    n_mag_zero = (i_value == '0);
                    n_shreg    = CONV_BITS'(in_mag);
                    n_bcd      = '0;
                    n_cnt      = STEP_W'(CONV_STEPS);
                end
            end
            OP_CONV: begin
                n_bcd   = dab_bcd;
                n_shreg = dab_sh;
                n_cnt   = r_cnt - STEP_W'(1);
            end
            OP_MEASURE: begin
                // zero with precision zero prints no digits
                if (r_prec_en && (r_prec == '0) && r_mag_zero)
                    n_ndig = '0;
                else
                    n_ndig = meas_ndig;
            end
            OP_PLAN1: begin
                n_zeros = body - ndig_ext;
                n_len   = body + CNT_W'(r_neg);
            end
            OP_PLAN2: begin
                n_left = (total > CNT_W'(MAX_WIDTH)) ? LEFT_W'(MAX_WIDTH) : total[LEFT_W-1:0];
                if (zero_fill) begin
                    n_zeros = r_zeros + pad_raw;
                    n_pad   = '0;
                end else begin
                    n_pad   = pad_raw;
                end
            end
            OP_EMIT: begin
                if (emit_fire) begin
                    n_out_char = seg_char;
                    n_out_last = (r_left == LEFT_W'(1));
                    n_left     = r_left - LEFT_W'(1);
                    unique case (uw.seg)
                        SEG_LEAD, SEG_TRAIL: n_pad   = r_pad - CNT_W'(1);
                        SEG_SIGN:            n_neg   = 1'b0;
                        SEG_ZEROS:           n_zeros = r_zeros - CNT_W'(1);
                        SEG_DIGITS:          n_ndig  = r_ndig - DIG_W'(1);
                        default:             n_pad   = r_pad;
                    endcase
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase

        if (emit_fire)
            n_out_valid = 1'b1;
        else if (i_out_ready)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_align  <= 1'b0;
            r_zero_pad    <= 1'b0;
            r_field_width <= '0;
            r_prec_en     <= 1'b0;
            r_prec        <= '0;
            r_cnt         <= '0;
            r_left        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LEFT_ALIGN:  r_left_align  <= i_cfg_data[0];
                    CFG_ZERO_PAD:    r_zero_pad    <= i_cfg_data[0];
                    CFG_FIELD_WIDTH: r_field_width <= i_cfg_data[FW_W-1:0];
                    CFG_PREC_EN:     r_prec_en     <= i_cfg_data[0];
                    CFG_PREC_DIGITS: r_prec        <= i_cfg_data[PREC_W-1:0];
                    default:         r_prec        <= r_prec;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_mag_zero <= n_mag_zero;
        r_shreg    <= n_shreg;
        r_bcd      <= n_bcd;
        r_ndig     <= n_ndig;
        r_zeros    <= n_zeros;
        r_len      <= n_len;
        r_pad      <= n_pad;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_char_out  = r_out_char;
    assign o_last_char = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a new value is only taken once every character of the last one went out
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_left == '0))
        else $error("input ready with characters still owed");

    // an input transfer starts the conversion loop
    a_xfer_to_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (uw.op == OP_CONV))
        else $error("sequencer did not enter conversion");

    // conversion loop never runs with an exhausted step count
    a_conv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == OP_CONV) |-> (r_cnt != '0))
        else $error("conversion step with zero count");

    // digit segment always produces a decimal digit
    a_digit_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && (uw.seg == SEG_DIGITS)) |=>
            ((r_out_char >= CHAR_ZERO) && (r_out_char <= CHAR_ZERO + CHAR_W'(9))))
        else $error("digit segment emitted a non-digit");

    // the final character of a value carries the mark
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && (r_left == LEFT_W'(1))) |=> (o_out_valid && o_last_char))
        else $error("final character not marked");

endmodule

### sv/sdf_seq.sv
// ----------------------------------------------------------------------------
// sdf_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
module sdf_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sdf_pkg::t_flags i_flags,
    output sdf_pkg::t_uword o_uword
);
    import sdf_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uw;
    logic            take;

    assign uw      = ucode(r_pc);
    assign o_uword = uw;

    always_comb begin
        unique case (uw.cond)
            C_NEVER:  take = 1'b0;
            C_ALWAYS: take = 1'b1;
            C_NO_IN:  take = !i_flags.in_xfer;
            C_LOOP:   take = i_flags.loop;
            C_BUSY:   take = i_flags.busy;
            default:  take = 1'b1;
        endcase
        n_pc = take ? uw.target : r_pc + PC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives signed_decimal_field_formatter_core with directed and random
// integers under many field setups. An internal formatter predicts each
// character stream. Every output transfer is checked in order against it,
// both the character and the last-character mark.
// ----------------------------------------------------------------------------
module testbench;
    import sdf_pkg::*;

    localparam int VB            = VALUE_BITS_DEF;
    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 12;
    // quiet cycles tolerated before giving up: the hold-off below is the
    // longest legal stretch, so this sits well above it
    localparam int STALL_LIMIT   = 4000;
    // covers an item that yields no characters and is still in flight
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int RAND_SEGMENTS = 8;
    localparam int SEG_ITEMS     = 50;
    localparam int PRESSURE_SEG  = 4;
    localparam int MAX_PRINTED   = 100;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the field registers, turns each
    // accepted integer into the characters it should produce, and checks
    // output transfers against them in order.
    // ------------------------------------------------------------------
    class t_decimal_text_board;
        t_text_char      due_chars[$];
        bit              left_align;
        bit              zero_pad;
        bit [FW_W-1:0]   field_width;
        bit              prec_en;
        bit [PREC_W-1:0] prec_digits;
        int              errors;
        int              values_seen;
        int              chars_seen;

        function new();
            left_align  = 1'b0;
            zero_pad    = 1'b0;
            field_width = '0;
            prec_en     = 1'b0;
            prec_digits = '0;
            errors      = 0;
            values_seen = 0;
            chars_seen  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LEFT_ALIGN:  left_align  = data[0];
                CFG_ZERO_PAD:    zero_pad    = data[0];
                CFG_FIELD_WIDTH: field_width = data[FW_W-1:0];
                CFG_PREC_EN:     prec_en     = data[0];
                CFG_PREC_DIGITS: prec_digits = data[PREC_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_value(logic signed [VB-1:0] num);
            t_text_char    text[$];
            logic [VB-1:0] mag;
            logic [VB-1:0] rest;
            logic [3:0]    digs[24];
            int            ndig;
            int            prec;
            int            body;
            int            zeros;
            int            len;
            int            pad;
            int            k;
            bit            neg;

            neg = num[VB-1];
            // most negative value wraps to its true unsigned magnitude
            mag = neg ? ~num + 1'b1 : num;

            // zero at precision zero prints no digits at all
            ndig = 0;
            if (!(prec_en && prec_digits == 0 && mag == 0)) begin
                rest = mag;
                do begin
                    digs[ndig] = 4'(rest % 10);
                    ndig++;
                    rest = rest / 10;
                end while (rest != 0);
            end

            prec  = (prec_digits > MAX_W - 1) ? MAX_W - 1 : prec_digits;
            body  = ndig;
            if (prec_en && prec > body)
                body = prec;
            zeros = body - ndig;
            len   = body + (neg ? 1 : 0);
            pad   = (field_width > len) ? field_width - len : 0;

            // zero fill only for right aligned text without a precision
            if (zero_pad && !left_align && !prec_en) begin
                zeros += pad;
                pad    = 0;
            end

            if (!left_align)
                repeat (pad) text.push_back(t_text_char'{CHAR_SPACE, 1'b0});
            if (neg)
                text.push_back(t_text_char'{CHAR_MINUS, 1'b0});
            repeat (zeros) text.push_back(t_text_char'{CHAR_ZERO, 1'b0});
            for (k = ndig - 1; k >= 0; k--)
                text.push_back(t_text_char'{CHAR_ZERO + CHAR_W'(digs[k]), 1'b0});
            if (left_align)
                repeat (pad) text.push_back(t_text_char'{CHAR_SPACE, 1'b0});

            while (text.size() > MAX_W)
                void'(text.pop_back());
            if (text.size() > 0)
                text[text.size() - 1].last = 1'b1;

            values_seen++;
            for (k = 0; k < text.size(); k++)
                due_chars.push_back(text[k]);
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("mismatch %0d: %s", errors, what);
        endtask

        task check_char(logic [CHAR_W-1:0] ch, logic last);
            t_text_char want;
            chars_seen++;
            if (due_chars.size() == 0) begin
                report($sformatf("char 0x%02h last=%0b with nothing outstanding", ch, last));
            end else begin
                want = due_chars.pop_front();
                if (ch !== want.ch)
                    report($sformatf("char 0x%02h, wanted 0x%02h", ch, want.ch));
                if (last !== want.last)
                    report($sformatf("last mark %0b on char 0x%02h, wanted %0b",
                                     last, ch, want.last));
            end
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic signed [VB-1:0]   i_value;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [CHAR_W-1:0]      o_char_out;
    logic                   o_last_char;

    t_decimal_text_board board;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  out_hold;
    int  cfg_writes;

    signed_decimal_field_formatter_core #(
        .VALUE_BITS (VB),
        .MAX_WIDTH  (MAX_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_out  (o_char_out),
        .o_last_char (o_last_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Driver tasks. Everything changes on the falling edge; handshakes
    // are sampled on the rising edge.
    // ------------------------------------------------------------------
    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct  = 80;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct = 80;
            end
            default: begin
                send_idle_pct  = 12;
                recv_stall_pct = 12;
            end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        board.set_reg(idx, data);
        cfg_writes++;
    endtask

    // Writes every field register; the single-bit ones carry random upper
    // bits, and the unused indexes get random data that must be dropped.
    task automatic apply_setup(input bit la, input bit zp, input bit [FW_W-1:0] fw,
                               input bit pe, input bit [PREC_W-1:0] pd);
        logic [CFG_DATA_W-1:0] noise;
        int                    k;
        noise = CFG_DATA_W'($urandom);
        write_reg(CFG_LEFT_ALIGN, {noise[CFG_DATA_W-1:1], la});
        noise = CFG_DATA_W'($urandom);
        write_reg(CFG_ZERO_PAD, {noise[CFG_DATA_W-1:1], zp});
        write_reg(CFG_FIELD_WIDTH, CFG_DATA_W'(fw));
        noise = CFG_DATA_W'($urandom);
        write_reg(CFG_PREC_EN, {noise[CFG_DATA_W-1:1], pe});
        write_reg(CFG_PREC_DIGITS, CFG_DATA_W'(pd));
        for (k = int'(CFG_PREC_DIGITS) + 1; k < 2 ** CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one integer, with random idle cycles ahead of it, and holds
    // it until the transfer happens.
    task automatic send_value(input int num);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_value    <= $urandom;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= num;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        board.note_value(num);
    endtask

    // Drops valid, waits for every outstanding character, then lets the
    // block settle so the next register writes find it idle.
    task automatic finish_phase();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.due_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Long receiver hold-off; the sender keeps offering meanwhile so the
    // block backs up and drops its input ready.
    task automatic hold_receiver();
        @(posedge i_clk);
        out_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        out_hold = 1'b0;
    endtask

    // Mostly short widths and precisions, with both extremes now and then.
    function automatic bit [FW_W-1:0] pick_size();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return FW_W'($urandom_range(14));
        endcase
    endfunction

    function automatic int pick_value();
        int p;
        case ($urandom_range(7))
            0: return 0;
            1: return $urandom_range(40) - 20;
            2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            3: begin
                // around a power of ten, where the digit count changes
                p = 1;
                repeat ($urandom_range(9)) p = p * 10;
                p = p + $urandom_range(2) - 1;
                return $urandom_range(1) ? -p : p;
            end
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side: random ready, and the check of each output transfer.
    // ------------------------------------------------------------------
    initial begin : char_sink
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : char_monitor
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                board.check_char(o_char_out, o_last_char);
        end
    end

    // Ends the run when no transfer of either kind happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("stalled: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : main_flow
        int              seg;
        bit              la;
        bit              zp;
        bit              pe;
        bit [FW_W-1:0]   fw;
        bit [PREC_W-1:0] pd;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_value        = '0;
        out_hold       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg_writes     = 0;
        board          = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers at their reset values: plain %d
        set_idling(IDLE_NONE);
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        send_value(1000000000);
        finish_phase();

        // precision zero: zero prints nothing, with no width no transfer
        apply_setup(1'b0, 1'b0, 6'd0, 1'b1, 6'd0);
        send_value(0);
        send_value(-3);
        finish_phase();

        // zero at precision zero inside a width: spaces only, both sides
        apply_setup(1'b0, 1'b0, 6'd5, 1'b1, 6'd0);
        send_value(0);
        finish_phase();
        apply_setup(1'b1, 1'b0, 6'd5, 1'b1, 6'd0);
        send_value(0);
        finish_phase();

        // zero fill across the width, sign ahead of the zeros
        apply_setup(1'b0, 1'b1, 6'd12, 1'b0, 6'd0);
        send_value(-42);
        send_value(32'sh7FFF_FFFF);
        finish_phase();

        // zero fill ignored under left alignment, then under a precision
        apply_setup(1'b1, 1'b1, 6'd12, 1'b0, 6'd0);
        send_value(-42);
        finish_phase();
        apply_setup(1'b0, 1'b1, 6'd8, 1'b1, 6'd3);
        send_value(-7);
        send_value(12345);
        finish_phase();

        // widest field, precision beyond the cap
        apply_setup(1'b0, 1'b0, 6'd63, 1'b1, 6'd63);
        send_value(32'sh8000_0000);
        send_value(0);
        finish_phase();
        apply_setup(1'b1, 1'b0, 6'd63, 1'b0, 6'd0);
        send_value(32'sh8000_0000);
        send_value(9);
        finish_phase();
        apply_setup(1'b0, 1'b1, 6'd63, 1'b0, 6'd0);
        send_value(-1);
        finish_phase();

        // random segments, each with its own setup and idling mode
        for (seg = 0; seg < RAND_SEGMENTS; seg++) begin
            la = $urandom_range(1);
            zp = $urandom_range(1);
            pe = $urandom_range(1);
            fw = pick_size();
            pd = pick_size();
            if (seg == 1) begin
                fw = '1;
                pe = 1'b1;
                pd = '1;
            end else if (seg == 2) begin
                fw = '0;
                pe = 1'b1;
                pd = '0;
            end
            apply_setup(la, zp, fw, pe, pd);
            set_idling(t_idle_mode'(seg % 4));
            if (seg == PRESSURE_SEG) begin
                fork
                    hold_receiver();
                join_none
            end
            repeat (SEG_ITEMS) send_value(pick_value());
            finish_phase();
        end

        $display("covered %0d integers, %0d characters checked, %0d register writes",
                 board.values_seen, board.chars_seen, cfg_writes);
        $display("directed edge cases plus %0d random setups over four idling modes",
                 RAND_SEGMENTS);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule
